>>> hw/rtl/scgr_pkg.sv
// Shared constants, types and gradient arithmetic for the Scharr gradient block.
// No dependencies; used by the top level scharr_gradient_reflect_border.
`timescale 1ns / 1ps
`default_nettype none

package scgr_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int PIX_W  = 8;
    localparam int CFG_W  = 11;
    localparam int IDX_W  = 2;
    localparam int GRAD_W = 13;
    localparam int POS_W  = 10;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;

    localparam logic signed [GRAD_W-1:0] WEIGHT_EDGE = 13'sd3;
    localparam logic signed [GRAD_W-1:0] WEIGHT_MID  = 13'sd10;

    typedef logic [COL_W:0] wsize_t;
    typedef logic [ROW_W:0] hsize_t;

    // [row][col]: row 0 two rows up, row 2 current; col 2 newest
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    function automatic wsize_t clamp_width(logic [CFG_W-1:0] v);
        if (int'(v) < 2) begin
            return wsize_t'(2);
        end
        if (int'(v) > MAX_WIDTH) begin
            return wsize_t'(MAX_WIDTH);
        end
        return wsize_t'(v);
    endfunction

    function automatic hsize_t clamp_height(logic [CFG_W-1:0] v);
        if (int'(v) < 2) begin
            return hsize_t'(2);
        end
        if (int'(v) > MAX_HEIGHT) begin
            return hsize_t'(MAX_HEIGHT);
        end
        return hsize_t'(v);
    endfunction

    function automatic logic signed [GRAD_W-1:0] pix_s(logic [PIX_W-1:0] v);
        return $signed({{(GRAD_W-PIX_W){1'b0}}, v});
    endfunction

    function automatic logic signed [GRAD_W-1:0] grad_x(win_t w, logic [1:0] u,
            logic [1:0] m, logic [1:0] d, logic [1:0] l, logic [1:0] r);
        logic signed [GRAD_W-1:0] s_edge;
        logic signed [GRAD_W-1:0] s_mid;
        s_edge = pix_s(w[u][r]) - pix_s(w[u][l]) + pix_s(w[d][r]) - pix_s(w[d][l]);
        s_mid  = pix_s(w[m][r]) - pix_s(w[m][l]);
        return s_edge * WEIGHT_EDGE + s_mid * WEIGHT_MID;
    endfunction

    function automatic logic signed [GRAD_W-1:0] grad_y(win_t w, logic [1:0] u,
            logic [1:0] d, logic [1:0] l, logic [1:0] c, logic [1:0] r);
        logic signed [GRAD_W-1:0] s_edge;
        logic signed [GRAD_W-1:0] s_mid;
        s_edge = pix_s(w[d][r]) - pix_s(w[u][r]) + pix_s(w[d][l]) - pix_s(w[u][l]);
        s_mid  = pix_s(w[d][c]) - pix_s(w[u][c]);
        return s_edge * WEIGHT_EDGE + s_mid * WEIGHT_MID;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/scgr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module scgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/scharr_gradient_reflect_border.sv
// Top level: streaming 3x3 Scharr gradient with reflect-101 borders.
// Depends on scgr_pkg and scgr_ram (two line stores).
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | s_valid s_ready s_pixel                 | in
//   result  | m_valid m_ready m_grad_x m_grad_y       | out
//           | m_out_col m_out_row m_run_last          |
//           | m_frame_last                            |
//   config  | cfg_we cfg_index cfg_wdata              | in
//
// One pixel per cycle while nothing stalls; the line store read is registered, results leave one per
// cycle from a job register when m_ready allows, so a pixel causing several results holds the input
// until its last result leaves the job register. Each item passes the line store stage and the job register.
// aresetn is synchronous; no clearing pass, line stores start undefined.
// m_ready low stalls the job register, then the line store stage, then s_ready.
`timescale 1ns / 1ps
`default_nettype none

module scharr_gradient_reflect_border (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [scgr_pkg::PIX_W-1:0]        s_pixel,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [scgr_pkg::GRAD_W-1:0]     m_grad_x,
    output logic signed [scgr_pkg::GRAD_W-1:0]     m_grad_y,
    output logic [scgr_pkg::POS_W-1:0]             m_out_col,
    output logic [scgr_pkg::POS_W-1:0]             m_out_row,
    output logic                                   m_run_last,
    output logic                                   m_frame_last,
    input  wire logic                              cfg_we,
    input  wire logic [scgr_pkg::IDX_W-1:0]        cfg_index,
    input  wire logic [scgr_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int COL_W = scgr_pkg::COL_W;
    localparam int ROW_W = scgr_pkg::ROW_W;
    localparam int PIX_W = scgr_pkg::PIX_W;

    // configuration
    logic [scgr_pkg::CFG_W-1:0] frame_width_reg;
    logic [scgr_pkg::CFG_W-1:0] frame_height_reg;
    scgr_pkg::wsize_t           w_use;
    scgr_pkg::hsize_t           h_use;

    // position counters
    logic [COL_W-1:0] col_reg, col_next, c_cur;
    logic [ROW_W-1:0] row_reg, row_next, r_cur;
    logic             c_end, r_end;
    logic [3:0]       mask_cur;

    // line store stage
    logic             v1_reg;
    logic [PIX_W-1:0] p1_reg;
    logic [COL_W-1:0] c1_reg;
    logic [ROW_W-1:0] r1_reg;
    logic [3:0]       mask1_reg;
    logic             cf1_reg, rf1_reg;
    logic [PIX_W-1:0] older_rd, newer_rd;
    scgr_pkg::win_t   win_reg, win_next;

    // job register
    logic             job_v_reg;
    logic [3:0]       job_mask_reg, job_sel, job_rest;
    scgr_pkg::win_t   job_win_reg;
    logic [COL_W-1:0] job_c_reg;
    logic [ROW_W-1:0] job_r_reg;
    logic             job_cf_reg, job_rf_reg;
    logic             prev_col, prev_row;
    logic [1:0]       ix_u, ix_m, ix_d, ix_l, ix_c, ix_r;
    logic [COL_W-1:0] res_col;
    logic [ROW_W-1:0] res_row;

    logic acc, adv1, out_ok, emit, job_done;

    assign w_use = scgr_pkg::clamp_width(frame_width_reg);
    assign h_use = scgr_pkg::clamp_height(frame_height_reg);

    always_comb begin
        c_cur = col_reg;
        r_cur = row_reg;
        if ({1'b0, col_reg} >= w_use) begin
            c_cur = COL_W'(w_use - scgr_pkg::wsize_t'(1));
        end
        if ({1'b0, row_reg} >= h_use) begin
            r_cur = ROW_W'(h_use - scgr_pkg::hsize_t'(1));
        end
        c_end = ({1'b0, c_cur} == w_use - scgr_pkg::wsize_t'(1));
        r_end = ({1'b0, r_cur} == h_use - scgr_pkg::hsize_t'(1));
        // bit 0: row above, left; 1: row above, last col; 2/3: same for this row
        mask_cur[0] = (r_cur != '0) && (c_cur != '0);
        mask_cur[1] = (r_cur != '0) && c_end;
        mask_cur[2] = r_end && (c_cur != '0);
        mask_cur[3] = r_end && c_end;
        if (c_end) begin
            col_next = '0;
            row_next = r_end ? '0 : r_cur + ROW_W'(1);
        end else begin
            col_next = c_cur + COL_W'(1);
            row_next = r_cur;
        end
    end

    assign out_ok   = !m_valid || m_ready;
    assign emit     = job_v_reg && out_ok;
    assign job_sel  = job_mask_reg & (~job_mask_reg + 4'd1);
    assign job_rest = job_mask_reg & ~job_sel;
    assign job_done = emit && (job_rest == 4'd0);
    assign adv1     = v1_reg && (!job_v_reg || job_done);
    assign s_ready  = aresetn && (!v1_reg || adv1);
    assign acc      = s_valid && s_ready;

    scgr_ram #(.WIDTH(PIX_W), .DEPTH(scgr_pkg::MAX_WIDTH)) u_older_line (
        .aclk  (aclk),
        .we    (adv1),
        .waddr (c1_reg),
        .wdata (newer_rd),
        .re    (acc),
        .raddr (c_cur),
        .rdata (older_rd)
    );

    scgr_ram #(.WIDTH(PIX_W), .DEPTH(scgr_pkg::MAX_WIDTH)) u_newer_line (
        .aclk  (aclk),
        .we    (adv1),
        .waddr (c1_reg),
        .wdata (p1_reg),
        .re    (acc),
        .raddr (c_cur),
        .rdata (newer_rd)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = older_rd;
        win_next[1][2] = newer_rd;
        win_next[2][2] = p1_reg;
    end

    always_comb begin
        prev_col = job_sel[0] || job_sel[2];
        prev_row = job_sel[0] || job_sel[1];
        ix_l = prev_col ? (job_cf_reg ? 2'd2 : 2'd0) : 2'd1;
        ix_c = prev_col ? 2'd1 : 2'd2;
        ix_r = prev_col ? 2'd2 : 2'd1;
        ix_u = prev_row ? (job_rf_reg ? 2'd2 : 2'd0) : 2'd1;
        ix_m = prev_row ? 2'd1 : 2'd2;
        ix_d = prev_row ? 2'd2 : 2'd1;
        res_col = prev_col ? job_c_reg - COL_W'(1) : job_c_reg;
        res_row = prev_row ? job_r_reg - ROW_W'(1) : job_r_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= scgr_pkg::RESET_WIDTH;
            frame_height_reg <= scgr_pkg::RESET_HEIGHT;
            col_reg          <= '0;
            row_reg          <= '0;
            v1_reg           <= 1'b0;
            job_v_reg        <= 1'b0;
            job_mask_reg     <= '0;
            m_valid          <= 1'b0;
            win_reg          <= '0;
        end else begin
            if (cfg_we && (cfg_index == scgr_pkg::REG_FRAME_WIDTH ||
                           cfg_index == scgr_pkg::REG_FRAME_HEIGHT)) begin
                if (cfg_index == scgr_pkg::REG_FRAME_WIDTH) begin
                    frame_width_reg <= cfg_wdata;
                end else begin
                    frame_height_reg <= cfg_wdata;
                end
                col_reg <= '0;
                row_reg <= '0;
            end else if (acc) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end

            if (acc) begin
                v1_reg <= 1'b1;
            end else if (adv1) begin
                v1_reg <= 1'b0;
            end

            if (adv1) begin
                win_reg      <= win_next;
                job_v_reg    <= (mask1_reg != 4'd0);
                job_mask_reg <= mask1_reg;
            end else if (emit) begin
                job_mask_reg <= job_rest;
                if (job_rest == 4'd0) begin
                    job_v_reg <= 1'b0;
                end
            end

            if (emit) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end

        if (acc) begin
            p1_reg    <= s_pixel;
            c1_reg    <= c_cur;
            r1_reg    <= r_cur;
            mask1_reg <= mask_cur;
            cf1_reg   <= (c_cur == COL_W'(1));
            rf1_reg   <= (r_cur == ROW_W'(1));
        end
        if (adv1) begin
            job_win_reg <= win_next;
            job_c_reg   <= c1_reg;
            job_r_reg   <= r1_reg;
            job_cf_reg  <= cf1_reg;
            job_rf_reg  <= rf1_reg;
        end
        if (emit) begin
            m_grad_x     <= scgr_pkg::grad_x(job_win_reg, ix_u, ix_m, ix_d, ix_l, ix_r);
            m_grad_y     <= scgr_pkg::grad_y(job_win_reg, ix_u, ix_d, ix_l, ix_c, ix_r);
            m_out_col    <= scgr_pkg::POS_W'(res_col);
            m_out_row    <= scgr_pkg::POS_W'(res_row);
            m_run_last   <= (job_rest == 4'd0);
            m_frame_last <= job_sel[3];
        end
    end

    a_col_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, col_reg} < w_use)
        else $error("column counter beyond frame width");

    a_job_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        job_v_reg |-> (job_mask_reg != 4'd0))
        else $error("job register holds no pending result");

    a_no_ram_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv1 && acc) |-> (c1_reg != c_cur))
        else $error("line store read and write hit the same column");

    a_frame_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_last) |-> m_run_last)
        else $error("bottom-right result is not the last of its item");

endmodule

`default_nettype wire

>>> verif/tb_scharr_gradient_reflect_border.sv
// Testbench for scharr_gradient_reflect_border: directed and random pixel frames with
// random input gaps and output stalls, every result checked against an in-bench predictor.
// Depends on scgr_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_scharr_gradient_reflect_border;

    localparam int PIX_W      = scgr_pkg::PIX_W;
    localparam int GRAD_W     = scgr_pkg::GRAD_W;
    localparam int POS_W      = scgr_pkg::POS_W;
    localparam int IDX_W      = scgr_pkg::IDX_W;
    localparam int CFG_W      = scgr_pkg::CFG_W;
    localparam int MAX_WIDTH  = scgr_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT = scgr_pkg::MAX_HEIGHT;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = scgr_pkg::REG_FRAME_WIDTH;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = scgr_pkg::REG_FRAME_HEIGHT;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 5;
    localparam int GAP_MAX       = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int RANDOM_ITEMS  = 400;
    localparam int PIX_MAX       = (1 << PIX_W) - 1;
    localparam int EDGE_WEIGHT   = int'(scgr_pkg::WEIGHT_EDGE);
    localparam int MID_WEIGHT    = int'(scgr_pkg::WEIGHT_MID);

    // indexes with no register behind them
    localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [POS_W-1:0]         col;
        logic [POS_W-1:0]         row;
        logic                     run_last;
        logic                     frame_last;
    } grad_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [PIX_W-1:0]         s_pixel;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [GRAD_W-1:0] m_grad_x;
    logic signed [GRAD_W-1:0] m_grad_y;
    logic [POS_W-1:0]         m_out_col;
    logic [POS_W-1:0]         m_out_row;
    logic                     m_run_last;
    logic                     m_frame_last;
    logic                     cfg_we;
    logic [IDX_W-1:0]         cfg_index;
    logic [CFG_W-1:0]         cfg_wdata;

    grad_t pending_grads[$];
    grad_t head_grad;
    int    error_count  = 0;
    int    cycle_count  = 0;
    int    pixels_sent  = 0;
    int    send_gap_max = GAP_MAX;
    int    stall_max    = GAP_MAX;

    // predictor state
    logic [PIX_W-1:0] line_far [MAX_WIDTH];
    logic [PIX_W-1:0] line_near [MAX_WIDTH];
    logic [PIX_W-1:0] taps [3][3];
    int unsigned      next_col;
    int unsigned      next_row;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    scharr_gradient_reflect_border dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_grad_x     (m_grad_x),
        .m_grad_y     (m_grad_y),
        .m_out_col    (m_out_col),
        .m_out_row    (m_out_row),
        .m_run_last   (m_run_last),
        .m_frame_last (m_frame_last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #(CLK_HALF);
        aclk = 1'b1;
        #(CLK_HALF);
    end

    function automatic int clamp_dim(logic [CFG_W-1:0] v, int hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic int tap_val(int r, int c);
        return int'(taps[r][c]);
    endfunction

    // window rows: 0 two up, 1 one up, 2 current; cols: 2 newest
    function automatic grad_t scharr_at(int unsigned col, int unsigned row, int lc, int cc,
                                        int rc, int ur, int mr, int dr, bit frame_end);
        int    gx_sum;
        int    gy_sum;
        grad_t g;
        gx_sum = (tap_val(ur, rc) - tap_val(ur, lc) + tap_val(dr, rc) - tap_val(dr, lc))
                 * EDGE_WEIGHT + (tap_val(mr, rc) - tap_val(mr, lc)) * MID_WEIGHT;
        gy_sum = (tap_val(dr, rc) - tap_val(ur, rc) + tap_val(dr, lc) - tap_val(ur, lc))
                 * EDGE_WEIGHT + (tap_val(dr, cc) - tap_val(ur, cc)) * MID_WEIGHT;
        g.gx         = gx_sum[GRAD_W-1:0];
        g.gy         = gy_sum[GRAD_W-1:0];
        g.col        = col[POS_W-1:0];
        g.row        = row[POS_W-1:0];
        g.run_last   = 1'b0;
        g.frame_last = frame_end;
        return g;
    endfunction

    task automatic predict_gradients(logic [PIX_W-1:0] p);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int          ur;
        int          n;
        int          i;
        grad_t       step_out[4];
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        c = next_col;
        r = next_row;
        n = 0;
        if (c >= w) c = w - 1;
        if (r >= h) r = h - 1;
        for (i = 0; i < 3; i++) begin
            taps[i][0] = taps[i][1];
            taps[i][1] = taps[i][2];
        end
        taps[0][2]   = line_far[c];
        taps[1][2]   = line_near[c];
        taps[2][2]   = p;
        line_far[c]  = line_near[c];
        line_near[c] = p;
        if (r >= 1) begin
            ur = (r == 1) ? 2 : 0;
            if (c >= 1) begin
                step_out[n] = scharr_at(c - 1, r - 1, (c == 1) ? 2 : 0, 1, 2, ur, 1, 2, 1'b0);
                n++;
            end
            if (c == w - 1) begin
                step_out[n] = scharr_at(c, r - 1, 1, 2, 1, ur, 1, 2, 1'b0);
                n++;
            end
        end
        if (r == h - 1) begin
            if (c >= 1) begin
                step_out[n] = scharr_at(c - 1, r, (c == 1) ? 2 : 0, 1, 2, 1, 2, 1, 1'b0);
                n++;
            end
            if (c == w - 1) begin
                step_out[n] = scharr_at(c, r, 1, 2, 1, 1, 2, 1, 1'b1);
                n++;
            end
        end
        for (i = 0; i < n; i++) begin
            step_out[i].run_last = (i == n - 1);
            pending_grads.push_back(step_out[i]);
        end
        if (c + 1 >= w) begin
            next_col = 0;
            next_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            next_col = c + 1;
            next_row = r;
        end
    endtask

    function automatic logic [PIX_W-1:0] noisy_pixel();
        case ($urandom_range(7, 0))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(PIX_MAX, 0));
        endcase
    endfunction

    task automatic send_pixel(logic [PIX_W-1:0] p);
        int gap;
        gap = $urandom_range(send_gap_max, 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_gradients(p);
        pixels_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_grads.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (idx == REG_FRAME_WIDTH) begin
            width_reg = val;
        end else if (idx == REG_FRAME_HEIGHT) begin
            height_reg = val;
        end else begin
            return;
        end
        next_col = 0;
        next_row = 0;
    endtask

    task automatic set_frame(logic [CFG_W-1:0] w_val, logic [CFG_W-1:0] h_val);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w_val);
        write_reg(REG_FRAME_HEIGHT, h_val);
    endtask

    // full-scale gradients of both signs; undersized registers saturate to 2
    task automatic test_gradient_extremes();
        logic [PIX_W-1:0] ramp [5];
        int               r;
        int               c;
        ramp = '{8'd0, 8'd128, 8'd255, 8'd128, 8'd0};
        send_gap_max = GAP_MAX;
        stall_max    = GAP_MAX;
        set_frame(11'd5, 11'd0);
        for (r = 0; r < 2; r++) begin
            for (c = 0; c < 5; c++) send_pixel(ramp[c]);
        end
        set_frame(11'd1, 11'd5);
        for (r = 0; r < 5; r++) begin
            for (c = 0; c < 2; c++) send_pixel(ramp[r]);
        end
    endtask

    // spare indexes leave the frame running; a real write restarts it
    task automatic test_restart_and_spare_index();
        set_frame(11'd3, 11'd3);
        repeat (5) send_pixel(noisy_pixel());
        wait_idle();
        write_reg(REG_SPARE_A, 11'h7FF);
        write_reg(REG_SPARE_B, CFG_W'($urandom_range(2047, 0)));
        repeat (4) send_pixel(noisy_pixel());
        repeat (4) send_pixel(noisy_pixel());
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, 11'd3);
        repeat (9) send_pixel(noisy_pixel());
    endtask

    task automatic test_random_frames();
        int               stop_at;
        int               w_eff;
        int               h_eff;
        int               total;
        int               pause_at;
        int               i;
        logic [CFG_W-1:0] w_val;
        logic [CFG_W-1:0] h_val;
        stop_at = pixels_sent + RANDOM_ITEMS;
        while (pixels_sent < stop_at) begin
            send_gap_max = ($urandom_range(3, 0) == 0) ? 0 : GAP_MAX;
            stall_max    = ($urandom_range(3, 0) == 0) ? 0 : GAP_MAX;
            case ($urandom_range(9, 0))
                0: w_val = CFG_W'($urandom_range(2047, 1025));
                1: w_val = CFG_W'($urandom_range(1, 0));
                default: w_val = CFG_W'($urandom_range(12, 2));
            endcase
            h_val = ($urandom_range(7, 0) == 0) ? CFG_W'($urandom_range(1, 0))
                                                : CFG_W'($urandom_range(8, 2));
            wait_idle();
            if ($urandom_range(3, 0) == 0) begin
                write_reg($urandom_range(1, 0) ? REG_SPARE_A : REG_SPARE_B,
                          CFG_W'($urandom_range(2047, 0)));
            end
            write_reg(REG_FRAME_WIDTH, w_val);
            write_reg(REG_FRAME_HEIGHT, h_val);
            w_eff = clamp_dim(w_val, MAX_WIDTH);
            h_eff = clamp_dim(h_val, MAX_HEIGHT);
            if (w_eff > 16) begin
                // oversized row: a short burst, abandoned by the next write
                total = $urandom_range(30, 1);
            end else begin
                total = w_eff * h_eff * $urandom_range(3, 1);
                if ($urandom_range(3, 0) == 0) total = $urandom_range(total - 1, 1);
            end
            pause_at = ($urandom_range(7, 0) == 0) ? $urandom_range(total - 1, 0) : -1;
            for (i = 0; i < total; i++) begin
                if (i == pause_at) wait_idle();
                send_pixel(noisy_pixel());
            end
        end
    endtask

    initial begin : result_stall
        int gap;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = $urandom_range(stall_max, 0);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    function automatic void check_field(string field, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_grads.size() == 0) begin
                $error("unexpected item: col %0d row %0d", m_out_col, m_out_row);
                error_count++;
            end else begin
                head_grad = pending_grads.pop_front();
                check_field("grad_x", int'(head_grad.gx), int'(m_grad_x));
                check_field("grad_y", int'(head_grad.gy), int'(m_grad_y));
                check_field("out_col", int'(head_grad.col), int'(m_out_col));
                check_field("out_row", int'(head_grad.row), int'(m_out_row));
                check_field("run_last", int'(head_grad.run_last), int'(m_run_last));
                check_field("frame_last", int'(head_grad.frame_last), int'(m_frame_last));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : main_seq
        int k;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_pixel   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        for (k = 0; k < MAX_WIDTH; k++) begin
            line_far[k]  = '0;
            line_near[k] = '0;
        end
        for (k = 0; k < 9; k++) taps[k / 3][k % 3] = '0;
        next_col   = 0;
        next_row   = 0;
        width_reg  = scgr_pkg::RESET_WIDTH;
        height_reg = scgr_pkg::RESET_HEIGHT;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_gradient_extremes();
        test_restart_and_spare_index();
        test_random_frames();

        wait_idle();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
